/* rtl/core/utd_pkg.sv */
// package: shared types and constants of the utf-8 to utf-16 decoder
package utd_pkg;

    // sequence decode constants
    localparam logic [7:0]  LEAD2_LO      = 8'hC2;
    localparam logic [7:0]  LEAD2_HI      = 8'hDF;
    localparam logic [7:0]  LEAD2_CHK     = 8'h1E;
    localparam logic [7:0]  CONT_MASK     = 8'hC0;
    localparam logic [7:0]  CONT_TAG      = 8'h80;
    localparam logic [7:0]  BYTE3_BIT     = 8'h20;
    localparam logic [7:0]  BYTE4_BITS    = 8'h30;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [20:0] CODE_MAX      = 21'h10FFFF;
    localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
    localparam logic [15:0] QMARK_UNIT    = 16'h003F;

    // run queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // what follows the leading replacement marks of a run
    typedef enum logic [1:0] {
        TAIL_NONE  = 2'd0,
        TAIL_UNIT  = 2'd1,
        TAIL_QMARK = 2'd2,
        TAIL_PAIR  = 2'd3
    } tail_kind_t;

    // all units caused by one input byte
    typedef struct packed {
        logic [2:0]  total;     // number of units, 1 to 4
        logic [1:0]  qcount;    // leading replacement marks
        tail_kind_t  tail;
        logic [19:0] tail_val;  // unit value, or code point minus 0x10000 for a pair
    } run_t;

endpackage

/* rtl/core/utd_if.sv */
// interfaces: byte input channel and code unit output channel
interface utd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface utd_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        replaced;
    logic        last_of_run;

    modport source (output valid, output code_unit, output replaced, output last_of_run,
                    input ready);
    modport sink   (input valid, input code_unit, input replaced, input last_of_run,
                    output ready);
endinterface

/* rtl/core/utf8_to_utf16_decoder_top.sv */
// top level: utf-8 byte stream in, utf-16 code units out
//
//   channel  dir  payload                                  transaction
//   bytes    in   in_byte[7:0], end_of_string              one utf-8 byte
//   units    out  code_unit[15:0], replaced, last_of_run   one utf-16 code unit
//
// one byte is taken per cycle while the four-entry run queue has room
// each run of units leaves at one unit per cycle while units is not stalled;
// a byte that gives no unit pushes no run into the queue
// a byte's first unit passes through a queue slot and then the output register
// rst_n is asynchronous, active low, and closes any open sequence
// a stall on units fills the queue and then drops bytes.ready
module utf8_to_utf16_decoder_top
    import utd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    utd_byte_if.sink   bytes,
    utd_unit_if.source units
);

    logic push;
    run_t push_run;
    logic full;
    logic pop;
    logic head_valid;
    run_t head_run;

    // byte decode
    utd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes    (bytes),
        .full     (full),
        .push     (push),
        .push_run (push_run)
    );

    // run queue
    utd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_run   (push_run),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_run   (head_run)
    );

    // unit emitter
    utd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_run   (head_run),
        .pop        (pop),
        .units      (units)
    );

endmodule

/* rtl/core/utd_front.sv */
// front end: accepts bytes, tracks the open sequence, builds one run per byte
module utd_front
    import utd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    utd_byte_if.sink   bytes,
    input  logic       full,
    output logic       push,
    output run_t       push_run
);

    logic [7:0]  lead_byte_reg,    lead_byte_next;
    logic [1:0]  bytes_needed_reg, bytes_needed_next;
    logic [1:0]  bytes_seen_reg,   bytes_seen_next;
    logic [20:0] code_accum_reg,   code_accum_next;

    logic        accept;
    run_t        run;

    // lead byte classification
    logic        is_ascii, is_lead2, is_lead3, is_lead4, is_lead;
    tail_kind_t  lt_kind;
    logic [19:0] lt_val;
    logic        lt_open;
    logic [1:0]  lt_need;
    logic [20:0] lt_acc;

    // continuation checks
    logic        overlong, cont_ok;
    logic [1:0]  seen1;
    logic [20:0] acc_new;
    logic [20:0] supp_off;

    assign accept      = bytes.valid && bytes.ready;
    assign bytes.ready = !full;

    // what the byte does when taken as a lead
    always_comb
    begin
        is_ascii = !bytes.in_byte[7];
        is_lead2 = (bytes.in_byte >= LEAD2_LO) && (bytes.in_byte <= LEAD2_HI);
        is_lead3 = (bytes.in_byte[7:4] == 4'hE);
        is_lead4 = (bytes.in_byte[7:3] == 5'b11110);
        is_lead  = is_lead2 || is_lead3 || is_lead4;
        lt_kind  = TAIL_QMARK;
        lt_val   = {12'd0, bytes.in_byte};
        lt_open  = 1'b0;
        lt_need  = 2'd1;
        lt_acc   = {16'd0, bytes.in_byte[4:0]};
        if (is_lead3)
        begin
            lt_need = 2'd2;
            lt_acc  = {17'd0, bytes.in_byte[3:0]};
        end
        else if (is_lead4)
        begin
            lt_need = 2'd3;
            lt_acc  = {18'd0, bytes.in_byte[2:0]};
        end
        if (is_ascii)
        begin
            lt_kind = TAIL_UNIT;
        end
        else if (is_lead && !bytes.end_of_string)
        begin
            lt_kind = TAIL_NONE;
            lt_open = 1'b1;
        end
    end

    // continuation byte checks, overlong test on byte two only
    always_comb
    begin
        overlong = 1'b0;
        case (bytes_needed_reg)
            2'd1:    overlong = (lead_byte_reg & LEAD2_CHK) == 8'd0;
            2'd2:    overlong = (lead_byte_reg[3:0] == 4'd0) &&
                                ((bytes.in_byte & BYTE3_BIT) == 8'd0);
            2'd3:    overlong = (lead_byte_reg[2:0] == 3'd0) &&
                                ((bytes.in_byte & BYTE4_BITS) == 8'd0);
            default: overlong = 1'b0;
        endcase
        cont_ok  = ((bytes.in_byte & CONT_MASK) == CONT_TAG) &&
                   !((bytes_seen_reg == 2'd0) && overlong);
        seen1    = bytes_seen_reg + 2'd1;
        acc_new  = {code_accum_reg[14:0], bytes.in_byte[5:0]};
        supp_off = acc_new - SUPP_BASE;
    end

    // run and next sequence state
    always_comb
    begin
        lead_byte_next    = lead_byte_reg;
        bytes_needed_next = bytes_needed_reg;
        bytes_seen_next   = bytes_seen_reg;
        code_accum_next   = code_accum_reg;
        run               = '0;
        run.tail          = TAIL_NONE;
        if (bytes_needed_reg == 2'd0 || !cont_ok)
        begin
            // new lead, after marks for a dropped sequence if one was open
            if (bytes_needed_reg != 2'd0)
            begin
                run.qcount = bytes_seen_reg + 2'd1;
            end
            run.tail     = lt_kind;
            run.tail_val = lt_val;
            if (lt_open)
            begin
                lead_byte_next    = bytes.in_byte;
                bytes_needed_next = lt_need;
                bytes_seen_next   = 2'd0;
                code_accum_next   = lt_acc;
            end
            else
            begin
                lead_byte_next    = 8'd0;
                bytes_needed_next = 2'd0;
                bytes_seen_next   = 2'd0;
                code_accum_next   = 21'd0;
            end
        end
        else if (seen1 >= bytes_needed_reg)
        begin
            // sequence complete
            lead_byte_next    = 8'd0;
            bytes_needed_next = 2'd0;
            bytes_seen_next   = 2'd0;
            code_accum_next   = 21'd0;
            if (acc_new < SUPP_BASE)
            begin
                run.tail     = TAIL_UNIT;
                run.tail_val = {4'd0, acc_new[15:0]};
            end
            else if (acc_new <= CODE_MAX)
            begin
                run.tail     = TAIL_PAIR;
                run.tail_val = supp_off[19:0];
            end
            else
            begin
                run.tail = TAIL_QMARK;
            end
        end
        else if (bytes.end_of_string)
        begin
            // string ends inside the sequence
            run.qcount        = seen1 + 2'd1;
            lead_byte_next    = 8'd0;
            bytes_needed_next = 2'd0;
            bytes_seen_next   = 2'd0;
            code_accum_next   = 21'd0;
        end
        else
        begin
            bytes_seen_next = seen1;
            code_accum_next = acc_new;
        end
        case (run.tail)
            TAIL_NONE: run.total = {1'b0, run.qcount};
            TAIL_PAIR: run.total = {1'b0, run.qcount} + 3'd2;
            default:   run.total = {1'b0, run.qcount} + 3'd1;
        endcase
    end

    assign push     = accept && (run.total != 3'd0);
    assign push_run = run;

    // sequence state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_byte_reg    <= 8'd0;
            bytes_needed_reg <= 2'd0;
            bytes_seen_reg   <= 2'd0;
            code_accum_reg   <= 21'd0;
        end
        else if (accept)
        begin
            lead_byte_reg    <= lead_byte_next;
            bytes_needed_reg <= bytes_needed_next;
            bytes_seen_reg   <= bytes_seen_next;
            code_accum_reg   <= code_accum_next;
        end
    end

endmodule

/* rtl/core/utd_queue.sv */
// run queue: short fifo between the front end and the unit emitter
module utd_queue
    import utd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  run_t push_run,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output run_t head_run
);

    run_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_run   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule

/* rtl/core/utd_back.sv */
// back end: walks the head run one unit a cycle into the output register while units is not stalled
module utd_back
    import utd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  run_t       head_run,
    output logic       pop,
    utd_unit_if.source units
);

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg;
    logic [15:0] unit_reg;
    logic        rep_reg;
    logic        last_reg;

    logic        load;
    logic [2:0]  idx_ext;
    logic [2:0]  tail_idx;
    logic [15:0] unit_next;
    logic        rep_next;
    logic        last_next;

    assign load = head_valid && (!valid_reg || units.ready);

    // select the unit at the current position of the run
    always_comb
    begin
        idx_ext   = {1'b0, idx_reg};
        tail_idx  = idx_ext - {1'b0, head_run.qcount};
        unit_next = QMARK_UNIT;
        rep_next  = 1'b1;
        if (idx_ext >= {1'b0, head_run.qcount})
        begin
            case (head_run.tail)
                TAIL_UNIT:
                begin
                    unit_next = head_run.tail_val[15:0];
                    rep_next  = 1'b0;
                end
                TAIL_PAIR:
                begin
                    rep_next = 1'b0;
                    if (tail_idx == 3'd0)
                    begin
                        unit_next = HI_SURR_BASE | {6'd0, head_run.tail_val[19:10]};
                    end
                    else
                    begin
                        unit_next = LO_SURR_BASE | {6'd0, head_run.tail_val[9:0]};
                    end
                end
                default:
                begin
                    unit_next = QMARK_UNIT;
                    rep_next  = 1'b1;
                end
            endcase
        end
        last_next = (idx_ext == head_run.total - 3'd1);
        idx_next  = last_next ? 2'd0 : idx_reg + 2'd1;
    end

    assign pop = load && last_next;

    // position within the head run and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            idx_reg   <= idx_next;
            valid_reg <= 1'b1;
        end
        else if (units.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit_reg <= unit_next;
            rep_reg  <= rep_next;
            last_reg <= last_next;
        end
    end

    assign units.valid       = valid_reg;
    assign units.code_unit   = unit_reg;
    assign units.replaced    = rep_reg;
    assign units.last_of_run = last_reg;

endmodule

/* test/tb.sv */
// testbench: utf-8 to utf-16 decoder, byte stream in with units checked against a local decoder
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utd_pkg::*;

    // lead ranges of the 3- and 4-byte forms
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF7;

    localparam int RANDOM_BYTES = 142;
    localparam int CALM_TAIL    = 30;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        replaced;
        logic        last_of_run;
    } code_unit_t;

    logic clk;
    logic rst_n;

    utd_byte_if byte_ch ();
    utd_unit_if unit_ch ();

    utf8_to_utf16_decoder_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (byte_ch),
        .units (unit_ch)
    );

    byte_item_t byte_backlog [$];
    code_unit_t pending_units [$];

    // decoder state kept by the testbench
    logic [7:0]  seq_lead;
    logic [1:0]  seq_need;
    logic [1:0]  seq_seen;
    logic [20:0] seq_code;

    // units caused by the byte being decoded
    logic [15:0] run_unit [0:3];
    logic        run_rep [0:3];
    int          run_len;

    int         err_count;
    int         bytes_taken;
    int         units_seen;
    int         qmarks_seen;
    int         cycle_count;
    int         in_gap;
    int         out_stall;
    byte_item_t drv_item;
    code_unit_t want;

    task automatic put_unit(input logic [15:0] unit, input logic rep);
        run_unit[run_len] = unit;
        run_rep[run_len]  = rep;
        run_len++;
    endtask

    task automatic close_seq();
        seq_lead = '0;
        seq_need = '0;
        seq_seen = '0;
        seq_code = '0;
    endtask

    // byte taken with no sequence open
    task automatic take_lead(input logic [7:0] b, input logic eos);
        logic [1:0] need;
        logic [7:0] mask;
        need = 2'd0;
        mask = 8'h00;
        if (b < CONT_TAG)
        begin
            put_unit({8'h00, b}, 1'b0);
        end
        else
        begin
            if (b >= LEAD2_LO && b <= LEAD2_HI)
            begin
                need = 2'd1;
                mask = 8'h1F;
            end
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
            begin
                need = 2'd2;
                mask = 8'h0F;
            end
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
            begin
                need = 2'd3;
                mask = 8'h07;
            end
            if (need == 2'd0 || eos)
            begin
                put_unit(QMARK_UNIT, 1'b1);
            end
            else
            begin
                seq_lead = b;
                seq_need = need;
                seq_seen = 2'd0;
                seq_code = {13'd0, b & mask};
            end
        end
    endtask

    // works out the units one accepted byte causes
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        logic        ok;
        int          cnt;
        int          seen;
        logic [20:0] acc;
        logic [20:0] offs;
        run_len = 0;
        if (seq_need == 2'd0)
        begin
            take_lead(b, eos);
        end
        else
        begin
            ok = (b & CONT_MASK) == CONT_TAG;
            // overlong test applies to byte two only
            if (seq_seen == 2'd0)
            begin
                if (seq_need == 2'd1 && (seq_lead & LEAD2_CHK) == 8'h00)
                    ok = 1'b0;
                if (seq_need == 2'd2 && seq_lead[3:0] == 4'h0 && (b & BYTE3_BIT) == 8'h00)
                    ok = 1'b0;
                if (seq_need == 2'd3 && seq_lead[2:0] == 3'h0 && (b & BYTE4_BITS) == 8'h00)
                    ok = 1'b0;
            end
            if (!ok)
            begin
                cnt = 1 + seq_seen;
                if (cnt > 3)
                    cnt = 3;
                for (int i = 0; i < cnt; i++)
                    put_unit(QMARK_UNIT, 1'b1);
                close_seq();
                take_lead(b, eos);
            end
            else
            begin
                seen = seq_seen + 1;
                acc  = {seq_code[14:0], b[5:0]};
                if (seen >= seq_need)
                begin
                    close_seq();
                    if (acc < SUPP_BASE)
                    begin
                        put_unit(acc[15:0], 1'b0);
                    end
                    else if (acc <= CODE_MAX)
                    begin
                        offs = acc - SUPP_BASE;
                        put_unit(HI_SURR_BASE + {6'd0, offs[19:10]}, 1'b0);
                        put_unit(LO_SURR_BASE + {6'd0, offs[9:0]}, 1'b0);
                    end
                    else
                    begin
                        put_unit(QMARK_UNIT, 1'b1);
                    end
                end
                else if (eos)
                begin
                    // string ended inside the sequence
                    for (int i = 0; i < 1 + seen; i++)
                        put_unit(QMARK_UNIT, 1'b1);
                    close_seq();
                end
                else
                begin
                    seq_seen = seen[1:0];
                    seq_code = acc;
                end
            end
        end
        for (int i = 0; i < run_len; i++)
            pending_units.push_back({run_unit[i], run_rep[i], i == run_len - 1});
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic eos);
        byte_backlog.push_back({b, eos});
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // known values on all inputs from time zero
    initial
    begin
        byte_ch.valid         = 1'b0;
        byte_ch.in_byte       = 8'h00;
        byte_ch.end_of_string = 1'b0;
        unit_ch.ready         = 1'b0;
    end

    // byte driver: takes pending bytes, idles in bursts, predicts on each transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_ch.valid <= 1'b0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                decode_byte(byte_ch.in_byte, byte_ch.end_of_string);
                bytes_taken++;
            end
            if (byte_ch.valid && !byte_ch.ready)
            begin
                // hold the offered byte
            end
            else if (in_gap > 0)
            begin
                in_gap--;
                byte_ch.valid <= 1'b0;
            end
            else if (byte_backlog.size() == 0)
            begin
                byte_ch.valid <= 1'b0;
            end
            else if (byte_backlog.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
            begin
                in_gap = $urandom_range(1, 6) - 1;
                byte_ch.valid <= 1'b0;
            end
            else
            begin
                drv_item = byte_backlog.pop_front();
                byte_ch.valid         <= 1'b1;
                byte_ch.in_byte       <= drv_item.in_byte;
                byte_ch.end_of_string <= drv_item.end_of_string;
            end
        end
    end

    // unit monitor: checks each transaction, stalls in bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            unit_ch.ready <= 1'b0;
        end
        else
        begin
            if (unit_ch.valid && unit_ch.ready)
            begin
                units_seen++;
                if (unit_ch.replaced)
                    qmarks_seen++;
                if (pending_units.size() == 0)
                begin
                    $error("unexpected unit %h with nothing pending", unit_ch.code_unit);
                    err_count++;
                end
                else
                begin
                    want = pending_units.pop_front();
                    if (unit_ch.code_unit !== want.code_unit)
                    begin
                        $error("code_unit: expected %h, got %h", want.code_unit,
                               unit_ch.code_unit);
                        err_count++;
                    end
                    if (unit_ch.replaced !== want.replaced)
                    begin
                        $error("replaced: expected %b, got %b", want.replaced,
                               unit_ch.replaced);
                        err_count++;
                    end
                    if (unit_ch.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %b, got %b", want.last_of_run,
                               unit_ch.last_of_run);
                        err_count++;
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                unit_ch.ready <= 1'b0;
            end
            else if (byte_backlog.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
            begin
                out_stall = $urandom_range(1, 6) - 1;
                unit_ch.ready <= 1'b0;
            end
            else
            begin
                unit_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [7:0] seq_bytes [0:3];
        int         kind;
        int         len;
        int         cut;
        logic       broken;
        logic       last_eos;
        int         rand_bytes;

        err_count   = 0;
        bytes_taken = 0;
        units_seen  = 0;
        qmarks_seen = 0;
        cycle_count = 0;
        in_gap      = 0;
        out_stall   = 0;
        rand_bytes  = 0;
        close_seq();
        rst_n = 1'b0;

        // ascii extremes and a literal question mark
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b1);
        queue_byte(8'h3F, 1'b0);
        // stray bytes
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b1);
        // smallest two-byte form, largest with end of string
        queue_byte(8'hC2, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hDF, 1'b0);
        queue_byte(8'hBF, 1'b1);
        // overlong three-byte form, continuation then seen as a stray lead
        queue_byte(8'hE0, 1'b0);
        queue_byte(8'h80, 1'b0);
        // first supplementary code point, a surrogate pair
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h90, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);
        // just above the code point range
        queue_byte(8'hF4, 1'b0);
        queue_byte(8'h90, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);
        // bad continuation after two buffered bytes, itself a stray: four marks
        queue_byte(8'hF1, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // string ends inside a three-byte form, then a lead with end of string
        queue_byte(8'hE1, 1'b0);
        queue_byte(8'h80, 1'b1);
        queue_byte(8'hC3, 1'b1);
        // overlong four-byte form
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h80, 1'b0);

        // random sequences, mostly well formed
        while (rand_bytes < RANDOM_BYTES)
        begin
            kind   = $urandom_range(0, 9);
            broken = kind >= 8;
            if (broken)
                kind = $urandom_range(2, 6);
            len = 1;
            case (kind)
                0, 1: seq_bytes[0] = 8'($urandom_range(8'h00, 8'h7F));
                2:
                begin
                    len = 2;
                    seq_bytes[0] = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
                end
                3, 4:
                begin
                    len = 3;
                    seq_bytes[0] = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
                end
                5, 6:
                begin
                    len = 4;
                    seq_bytes[0] = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
                end
                default: seq_bytes[0] = 8'($urandom_range(0, 255));
            endcase
            for (int i = 1; i < len; i++)
                seq_bytes[i] = CONT_TAG | 8'($urandom_range(0, 63));
            // keep byte two clear of the overlong test
            if (len == 3 && seq_bytes[0] == LEAD3_LO)
                seq_bytes[1] = seq_bytes[1] | BYTE3_BIT;
            if (len == 4 && seq_bytes[0][2:0] == 3'h0)
                seq_bytes[1] = CONT_TAG | 8'($urandom_range(1, 3) << 4)
                               | 8'($urandom_range(0, 15));
            last_eos = $urandom_range(0, 7) == 0;
            if (broken)
            begin
                cut = $urandom_range(1, len - 1);
                if ($urandom_range(0, 1) == 0)
                begin
                    // corrupt a continuation
                    seq_bytes[cut] = 8'($urandom_range(0, 255));
                    len = cut + 1;
                end
                else
                begin
                    // string ends early
                    len = cut;
                    last_eos = 1'b1;
                end
            end
            for (int i = 0; i < len; i++)
                queue_byte(seq_bytes[i], (i == len - 1) ? last_eos : 1'b0);
            rand_bytes += len;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (byte_backlog.size() != 0 || byte_ch.valid || pending_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d utf-8 bytes decoded, %0d utf-16 units checked",
                 bytes_taken, units_seen);
        $display("summary: %0d replacement units among them", qmarks_seen);
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
